>>> hdl/x86rm_pkg.sv
`timescale 1ns / 1ps
package x86rm_pkg;
	localparam int STACK_WORDS_DEF = 32768;
	localparam int LEVEL_MASK_DEF = 31;
	localparam logic [15:0] HLE_SEG_RESET = 16'hF000;
	localparam logic [15:0] FLAG_OF = 16'h0800;
	localparam logic [15:0] FLAG_IF = 16'h0200;
	localparam logic [15:0] FLAG_TF = 16'h0100;

	typedef enum logic [3:0] {
		CMD_CALL_NEAR = 4'd0,
		CMD_CALL_FAR = 4'd1,
		CMD_RET_NEAR = 4'd2,
		CMD_RET_FAR = 4'd3,
		CMD_RET_NEAR_IMM = 4'd4,
		CMD_RET_FAR_IMM = 4'd5,
		CMD_ENTER = 4'd6,
		CMD_LEAVE = 4'd7,
		CMD_INT = 4'd8,
		CMD_IRET = 4'd9
	} cmd_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NULL_VEC = 2'd1;
	localparam logic [1:0] ST_ENTER32 = 2'd2;

	// one stack ram request from the sequencer
	typedef struct packed {
		logic        rd;
		logic        wr;
		logic [15:0] sp;
		logic [15:0] wdata;
	} ram_req_t;
endpackage

>>> hdl/x86_real_mode_call_return_unit.sv
`timescale 1ns / 1ps
// channel  | signals                       | direction
// in       | in_valid/in_ready + fields    | item in
// out      | out_valid/out_ready + fields  | result out
// cfg      | cfg_valid/cfg_ready, cfg_data | hle segment write
// one transaction at a time: a push is one S_PUSH state, while a pop or level copy
// reads the synchronous stack ram in S_POP or S_COPY and uses the word in S_POPW or
// S_COPYW; enter pushes bp, copies the outer frame pointers and pushes the frame
// pointer when the level is nonzero.
// results wait in the output register; a new item is taken once it drains.
// reset clears control and sets the hle segment; the stack ram is not cleared.
module x86_real_mode_call_return_unit #(
	parameter int STACK_WORDS = x86rm_pkg::STACK_WORDS_DEF,
	parameter int LEVEL_MASK = x86rm_pkg::LEVEL_MASK_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [3:0] command,
	input  logic [15:0] imm_word,
	input  logic [15:0] imm_segment,
	input  logic [7:0] byte_imm,
	input  logic only_if_overflow,
	input  logic [3:0] instr_len,
	input  logic operand_override,
	input  logic [15:0] cur_ip,
	input  logic [15:0] cur_cs,
	input  logic [15:0] cur_flags,
	input  logic [15:0] cur_sp,
	input  logic [15:0] cur_bp,
	output logic out_valid,
	input  logic out_ready,
	output logic [15:0] new_ip,
	output logic ip_absolute,
	output logic [15:0] new_cs,
	output logic [15:0] new_flags,
	output logic [15:0] new_sp,
	output logic [15:0] new_bp,
	output logic hle_call,
	output logic [1:0] status
);
	import x86rm_pkg::*;

	logic [15:0] hle_seg_q;
	ram_req_t req;
	logic [15:0] rdata;

	assign cfg_ready = 1'b1;

	// hle segment register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hle_seg_q <= HLE_SEG_RESET;
		else if (cfg_valid)
			hle_seg_q <= cfg_data;
	end

	x86rm_seq #(.LEVEL_MASK(LEVEL_MASK)) u_seq (
		.clk, .arst_n, .in_valid, .in_ready, .command, .imm_word, .imm_segment,
		.byte_imm, .only_if_overflow, .instr_len, .operand_override,
		.cur_ip, .cur_cs, .cur_flags, .cur_sp, .cur_bp,
		.hle_seg(hle_seg_q), .req, .rdata, .out_valid, .out_ready,
		.new_ip, .ip_absolute, .new_cs, .new_flags, .new_sp, .new_bp,
		.hle_call, .status
	);

	x86rm_stack_ram #(.STACK_WORDS(STACK_WORDS)) u_ram (
		.clk, .req, .rdata
	);
endmodule

>>> hdl/x86rm_stack_ram.sv
`timescale 1ns / 1ps
module x86rm_stack_ram #(
	parameter int STACK_WORDS = x86rm_pkg::STACK_WORDS_DEF
) (
	input  logic               clk,
	input  x86rm_pkg::ram_req_t req,
	output logic [15:0]        rdata
);
	import x86rm_pkg::*;
	localparam int AW = $clog2(STACK_WORDS);

	logic [15:0] mem [STACK_WORDS];
	logic [AW-1:0] addr;

	// word address from byte stack pointer
	assign addr = req.sp[AW:1];

	always_ff @(posedge clk) begin
		if (req.wr)
			mem[addr] <= req.wdata;
		if (req.rd)
			rdata <= mem[addr];
	end
endmodule

>>> hdl/x86rm_seq.sv
`timescale 1ns / 1ps
module x86rm_seq #(
	parameter int LEVEL_MASK = x86rm_pkg::LEVEL_MASK_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [3:0] command,
	input  logic [15:0] imm_word,
	input  logic [15:0] imm_segment,
	input  logic [7:0] byte_imm,
	input  logic only_if_overflow,
	input  logic [3:0] instr_len,
	input  logic operand_override,
	input  logic [15:0] cur_ip,
	input  logic [15:0] cur_cs,
	input  logic [15:0] cur_flags,
	input  logic [15:0] cur_sp,
	input  logic [15:0] cur_bp,
	input  logic [15:0] hle_seg,
	output x86rm_pkg::ram_req_t req,
	input  logic [15:0] rdata,
	output logic out_valid,
	input  logic out_ready,
	output logic [15:0] new_ip,
	output logic ip_absolute,
	output logic [15:0] new_cs,
	output logic [15:0] new_flags,
	output logic [15:0] new_sp,
	output logic [15:0] new_bp,
	output logic hle_call,
	output logic [1:0] status
);
	import x86rm_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PUSH = 6'b000010,
		S_POP  = 6'b000100,
		S_POPW = 6'b001000,
		S_COPY = 6'b010000,
		S_COPYW = 6'b100000
	} state_t;

	state_t state_q;
	logic [3:0] cmd_q;
	logic [15:0] imm_q, ip_q, cs_q, fl_q, sp_q, walk_q, frame_q;
	logic [4:0] lvl_q, cnt_q;
	logic [1:0] idx_q;
	logic [1:0] npush_q;
	logic [15:0] pw0_q, pw1_q, pw2_q;
	logic res_full_q;
	logic [4:0] lvl_in;
	logic [15:0] ret_in, sp_dec;

	assign lvl_in = byte_imm[4:0] & 5'(LEVEL_MASK);
	assign ret_in = cur_ip + 16'(instr_len);
	assign sp_dec = sp_q - 16'd2;
	assign in_ready = (state_q == S_IDLE) && !res_full_q;
	assign out_valid = res_full_q;

	// ram requests per state
	always_comb begin
		req = '0;
		unique case (state_q)
			S_PUSH: begin
				req.wr = 1'b1;
				req.sp = sp_dec;
				unique case (idx_q)
					2'd0: req.wdata = pw0_q;
					2'd1: req.wdata = pw1_q;
					default: req.wdata = pw2_q;
				endcase
			end
			S_POP: begin
				req.rd = 1'b1;
				req.sp = sp_q;
			end
			S_COPY: begin
				req.rd = 1'b1;
				req.sp = walk_q - 16'd2;
			end
			S_COPYW: begin
				req.wr = 1'b1;
				req.sp = sp_dec;
				req.wdata = rdata;
			end
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_full_q <= 1'b0;
		end else begin
			if (res_full_q && out_ready)
				res_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= command;
						imm_q <= imm_word;
						ip_q <= cur_ip;
						// target segment for far call and int
						cs_q <= imm_segment;
						fl_q <= cur_flags;
						sp_q <= cur_sp;
						walk_q <= cur_bp;
						lvl_q <= lvl_in;
						idx_q <= 2'd0;
						cnt_q <= 5'd1;
						new_ip <= cur_ip;
						new_cs <= cur_cs;
						new_flags <= cur_flags;
						new_sp <= cur_sp;
						new_bp <= cur_bp;
						ip_absolute <= 1'b0;
						hle_call <= 1'b0;
						status <= ST_OK;
						state_q <= S_IDLE;
						unique case (command)
							CMD_CALL_NEAR: begin
								pw0_q <= ret_in; npush_q <= 2'd1;
								state_q <= S_PUSH;
							end
							CMD_CALL_FAR: begin
								pw0_q <= cur_cs; pw1_q <= ret_in; npush_q <= 2'd2;
								state_q <= S_PUSH;
							end
							CMD_RET_NEAR, CMD_RET_FAR, CMD_RET_NEAR_IMM,
							CMD_RET_FAR_IMM, CMD_IRET: state_q <= S_POP;
							CMD_ENTER: begin
								if (operand_override && lvl_in > 5'd1) begin
									status <= ST_ENTER32;
									res_full_q <= 1'b1;
								end else begin
									pw0_q <= cur_bp; npush_q <= 2'd1;
									state_q <= S_PUSH;
								end
							end
							CMD_LEAVE: begin
								sp_q <= cur_bp;
								state_q <= S_POP;
							end
							CMD_INT: begin
								if (only_if_overflow && (cur_flags & FLAG_OF) == 16'd0)
									res_full_q <= 1'b1;
								else if (imm_word == 16'd0 && imm_segment == 16'd0) begin
									status <= ST_NULL_VEC;
									res_full_q <= 1'b1;
								end else if (imm_segment == hle_seg &&
									imm_word == {8'd0, byte_imm}) begin
									hle_call <= 1'b1;
									res_full_q <= 1'b1;
								end else begin
									pw0_q <= cur_flags; pw1_q <= cur_cs; pw2_q <= ret_in;
									npush_q <= 2'd3;
									state_q <= S_PUSH;
								end
							end
							default: res_full_q <= 1'b1;
						endcase
					end
				end
				S_PUSH: begin
					sp_q <= sp_dec;
					idx_q <= idx_q + 2'd1;
					if (idx_q + 2'd1 == npush_q) begin
						// all pushes of this step done
						priority if (cmd_q == CMD_ENTER && cnt_q == 5'd1) begin
							// bp pushed; frame pointer fixed
							frame_q <= sp_dec;
							cnt_q <= 5'd2;
							if (lvl_q == 5'd0) begin
								new_bp <= sp_dec;
								new_sp <= sp_dec - imm_q;
								res_full_q <= 1'b1;
								state_q <= S_IDLE;
							end else if (lvl_q == 5'd1) begin
								pw0_q <= sp_dec; idx_q <= 2'd0;
								state_q <= S_PUSH;
							end else
								state_q <= S_COPY;
						end else if (cmd_q == CMD_ENTER) begin
							new_bp <= frame_q;
							new_sp <= sp_dec - imm_q;
							res_full_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							new_sp <= sp_dec;
							if (cmd_q == CMD_CALL_NEAR)
								new_ip <= ip_q + imm_q;
							else begin
								new_ip <= imm_q;
								new_cs <= cs_q;
								ip_absolute <= 1'b1;
							end
							if (cmd_q == CMD_INT)
								new_flags <= fl_q & ~(FLAG_IF | FLAG_TF);
							res_full_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_COPY: begin
					walk_q <= walk_q - 16'd2;
					state_q <= S_COPYW;
				end
				S_COPYW: begin
					sp_q <= sp_dec;
					if (cnt_q == lvl_q) begin
						pw0_q <= frame_q; idx_q <= 2'd0;
						state_q <= S_PUSH;
					end else begin
						cnt_q <= cnt_q + 5'd1;
						state_q <= S_COPY;
					end
				end
				S_POP: begin
					state_q <= S_POPW;
				end
				S_POPW: begin
					sp_q <= sp_q + 16'd2;
					idx_q <= idx_q + 2'd1;
					state_q <= S_POP;
					if (cmd_q == CMD_LEAVE) begin
						new_bp <= rdata;
						new_sp <= sp_q + 16'd2;
						res_full_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (idx_q == 2'd0) begin
						new_ip <= rdata;
						ip_absolute <= 1'b1;
						if (cmd_q == CMD_RET_NEAR || cmd_q == CMD_RET_NEAR_IMM) begin
							new_sp <= sp_q + 16'd2 +
								((cmd_q == CMD_RET_NEAR_IMM) ? imm_q : 16'd0);
							res_full_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (idx_q == 2'd1) begin
						new_cs <= rdata;
						if (cmd_q != CMD_IRET) begin
							new_sp <= sp_q + 16'd2 +
								((cmd_q == CMD_RET_FAR_IMM) ? imm_q : 16'd0);
							res_full_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						new_flags <= rdata;
						new_sp <= sp_q + 16'd2;
						res_full_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
